FILE: hdl/bfa_pkg.sv
// bfa_pkg: shared constants for the bitmap fit allocator
// no dependencies
`default_nettype none
package bfa_pkg;
	localparam int MAP_SIZE_DEF = 256;
	localparam logic [2:0] KIND_FIRST = 3'd0;
	localparam logic [2:0] KIND_BEST  = 3'd1;
	localparam logic [2:0] KIND_WORST = 3'd2;
	localparam logic [2:0] KIND_NEXT  = 3'd3;
	localparam logic [2:0] KIND_MARK  = 3'd4;
endpackage
`default_nettype wire

FILE: hdl/bitmap_fit_allocator.sv
// bitmap_fit_allocator: occupancy bitmap allocator, first/best/worst/next fit and mark
// uses bfa_pkg; map held in one synchronous memory with registered read data
// a mark writes its one unit; a fit request reads the map one entry per cycle
// (first and next fit stop at the first run that fits, best and worst scan all
// entries and an end sentinel), then writes the granted run one unit per cycle; one request in flight at a time
// reset: after reset a clearing pass writes every map entry free,
// during which no request is taken; next-fit pointer resets to zero
`default_nettype none
module bitmap_fit_allocator
	import bfa_pkg::*;
#(
	parameter int MAP_SIZE = MAP_SIZE_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [2:0]  s_tuser,  // kind
	input  wire logic [23:0] s_tdata,  // request_length[8:0], mark_index[16:9], zero pad
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata   // granted[0], start_unit[8:1], zero pad
);
	localparam int AW = $clog2(MAP_SIZE);
	localparam int CW = AW + 1;

	localparam logic [2:0] ST_CLR  = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_SCAN = 3'd2;
	localparam logic [2:0] ST_FILL = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;

	logic [2:0]    state_q;
	logic          mem_q [MAP_SIZE];
	logic          rd_q;          // registered read data
	logic          rd_vld_q;      // rd_q holds entry pos_q-1
	logic [CW-1:0] pos_q;         // next address issued
	logic [CW-1:0] run_q;
	logic [2:0]    kind_q;
	logic [8:0]    len_q;
	logic          found_q;
	logic [CW-1:0] best_len_q;
	logic [CW-1:0] best_start_q;
	logic [CW-1:0] next_q;
	logic [CW-1:0] fill_q;
	logic [CW-1:0] fill_end_q;
	logic          granted_q;
	logic [7:0]    start_q;

	// write port
	logic          we;
	logic [AW-1:0] wa;
	logic          wd;

	// scan evaluation of entry pos_q-1 (or the end sentinel)
	logic [CW-1:0] idx, run_n, cand_start;
	logic          is_free, last;
	logic [CW-1:0] len_w;
	logic          better;

	assign len_w = CW'(len_q);
	assign idx = pos_q - CW'(1);
	assign last = (idx == CW'(MAP_SIZE));
	assign is_free = !last && !rd_q;
	assign run_n = is_free ? run_q + CW'(1) : '0;
	assign cand_start = idx - run_q;
	always_comb begin
		if (!found_q) better = 1'b1;
		else if (kind_q == KIND_WORST) better = run_q > best_len_q;
		else better = run_q < best_len_q;
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = (state_q == ST_OUT);
	assign m_tdata = {7'd0, start_q, granted_q};

	always_ff @(posedge clk) begin
		if (we) mem_q[wa] <= wd;
		if (pos_q < CW'(MAP_SIZE)) rd_q <= mem_q[pos_q[AW-1:0]];
		else rd_q <= 1'b1;
	end

	always_comb begin
		we = 1'b0;
		wa = fill_q[AW-1:0];
		wd = 1'b1;
		case (state_q)
			ST_CLR: begin
				we = 1'b1;
				wd = 1'b0;
			end
			ST_FILL: we = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			fill_q <= '0;
			next_q <= '0;
			pos_q <= '0;
			rd_vld_q <= 1'b0;
			granted_q <= 1'b0;
			start_q <= '0;
			found_q <= 1'b0;
			run_q <= '0;
			kind_q <= '0;
			len_q <= '0;
			best_len_q <= '0;
			best_start_q <= '0;
			fill_end_q <= '0;
		end else begin
			case (state_q)
				ST_CLR: begin
					// clearing pass, one entry per cycle
					fill_q <= fill_q + CW'(1);
					if (fill_q == CW'(MAP_SIZE - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: if (s_tvalid) begin
					kind_q <= s_tuser;
					len_q <= s_tdata[8:0];
					found_q <= 1'b0;
					run_q <= '0;
					best_len_q <= '0;
					best_start_q <= '0;
					granted_q <= 1'b0;
					start_q <= '0;
					rd_vld_q <= 1'b0;
					if (s_tuser == KIND_MARK) begin
						if (32'(s_tdata[16:9]) < 32'(MAP_SIZE)) begin
							fill_q <= CW'(s_tdata[16:9]);
							fill_end_q <= CW'(s_tdata[16:9]) + CW'(1);
							granted_q <= 1'b1;
							start_q <= s_tdata[16:9];
							state_q <= ST_FILL;
						end else state_q <= ST_OUT;
					end else if (s_tdata[8:0] == 9'd0 || 32'(s_tdata[8:0]) >
						32'(MAP_SIZE) || s_tuser > KIND_NEXT ||
						(s_tuser == KIND_NEXT && next_q >= CW'(MAP_SIZE))) begin
						state_q <= ST_OUT;
					end else begin
						pos_q <= (s_tuser == KIND_NEXT) ? next_q : '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (pos_q <= CW'(MAP_SIZE)) pos_q <= pos_q + CW'(1);
					rd_vld_q <= 1'b1;
					if (rd_vld_q) begin
						run_q <= run_n;
						if (kind_q == KIND_FIRST || kind_q == KIND_NEXT) begin
							// first run reaching the length wins
							if (is_free && run_n == len_w) begin
								best_start_q <= idx + CW'(1) - len_w;
								found_q <= 1'b1;
								state_q <= ST_FILL;
								fill_q <= idx + CW'(1) - len_w;
								fill_end_q <= idx + CW'(1);
							end else if (last) state_q <= ST_OUT;
						end else begin
							if (!is_free && run_q >= len_w && better) begin
								found_q <= 1'b1;
								best_len_q <= run_q;
								best_start_q <= cand_start;
							end
							if (last) begin
								// hole at end is closed in this same step
								if ((!is_free && run_q >= len_w && better) || found_q) begin
									fill_q <= (run_q >= len_w && better) ? cand_start
										: best_start_q;
									fill_end_q <= ((run_q >= len_w && better) ? cand_start
										: best_start_q) + len_w;
									state_q <= ST_FILL;
								end else state_q <= ST_OUT;
							end
						end
					end
				end
				ST_FILL: begin
					fill_q <= fill_q + CW'(1);
					if (fill_q + CW'(1) == fill_end_q) begin
						state_q <= ST_OUT;
						if (kind_q != KIND_MARK) begin
							granted_q <= 1'b1;
							start_q <= 8'(fill_end_q - len_w);
							next_q <= fill_end_q;
						end
					end
				end
				ST_OUT: if (m_tready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

FILE: verif/bitmap_fit_allocator_tb.sv
// bitmap_fit_allocator_tb: self-checking bench for the bitmap fit allocator
// uses bfa_pkg and bitmap_fit_allocator; predicts grants from its own copy of the map
`default_nettype none
module bitmap_fit_allocator_tb;
	import bfa_pkg::*;

	localparam int UNITS = 256;

	// expected grant for one request
	typedef struct packed {
		logic       granted;
		logic [7:0] start_unit;
	} grant_t;

	// tracks the allocator's map and holds grants still owed by the block
	class grant_board;
		bit         busy_map[UNITS];
		int         next_ptr;
		grant_t     owed[$];
		int         errors;

		function new();
			foreach (busy_map[i]) busy_map[i] = 0;
			next_ptr = 0;
			errors = 0;
		endfunction

		// lowest free run of len units at or after from
		function bit find_first(int from, int len, output int at);
			int run;
			run = 0;
			at = 0;
			for (int i = from; i < UNITS; i++) begin
				if (!busy_map[i]) begin
					run++;
					if (run == len) begin
						at = i + 1 - len;
						return 1;
					end
				end else begin
					run = 0;
				end
			end
			return 0;
		endfunction

		// smallest or largest maximal hole that fits; ties keep the lowest
		function bit find_hole(int len, bit biggest, output int at);
			bit found;
			int best_len, run;
			bit free_u, better;
			found = 0;
			best_len = 0;
			run = 0;
			at = 0;
			for (int i = 0; i <= UNITS; i++) begin
				free_u = (i < UNITS) && !busy_map[i];
				if (free_u) begin
					run++;
				end else begin
					if (run >= len && run > 0) begin
						if (!found) better = 1;
						else if (biggest) better = run > best_len;
						else better = run < best_len;
						if (better) begin
							found = 1;
							best_len = run;
							at = i - run;
						end
					end
					run = 0;
				end
			end
			return found;
		endfunction

		// note an accepted request and queue its grant
		function void note_request(logic [2:0] kind, int len, int mark);
			grant_t g;
			int at;
			bit ok;
			g = '0;
			ok = 0;
			at = 0;
			if (kind == KIND_MARK) begin
				busy_map[mark] = 1;
				g.granted = 1;
				g.start_unit = mark[7:0];
			end else begin
				if (len != 0 && len <= UNITS) begin
					case (kind)
						KIND_FIRST: ok = find_first(0, len, at);
						KIND_BEST:  ok = find_hole(len, 0, at);
						KIND_WORST: ok = find_hole(len, 1, at);
						KIND_NEXT: begin
							if (next_ptr < UNITS) ok = find_first(next_ptr, len, at);
						end
						default: ok = 0;
					endcase
				end
				if (ok) begin
					for (int i = 0; i < len; i++) busy_map[at + i] = 1;
					next_ptr = at + len;
					g.granted = 1;
					g.start_unit = at[7:0];
				end
			end
			owed.push_back(g);
		endfunction

		function void check_grant(logic [15:0] data);
			grant_t want;
			if (owed.size() == 0) begin
				$error("unexpected grant %h", data);
				errors++;
				return;
			end
			want = owed.pop_front();
			if (data[0] !== want.granted) begin
				$error("granted: expected %0d actual %0d", want.granted, data[0]);
				errors++;
			end
			if (data[8:1] !== want.start_unit) begin
				$error("start_unit: expected %0d actual %0d", want.start_unit, data[8:1]);
				errors++;
			end
			if (data[15:9] !== 7'd0) begin
				$error("pad: expected 0 actual %0d", data[15:9]);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [2:0]  s_tuser;   // kind
	logic [23:0] s_tdata;   // request_length[8:0], mark_index[16:9], zero pad
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;   // granted[0], start_unit[8:1], zero pad

	grant_board board;
	bit         hold_sink;     // forces the sink to stall for a long stretch
	int         idle_cycles = 0;

	bitmap_fit_allocator i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tuser (s_tuser),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// one request transfer after a random gap; the model is updated on acceptance
	task automatic send_request(logic [2:0] kind, logic [8:0] len, logic [7:0] mark,
			bit no_gap = 0);
		int gap;
		gap = no_gap ? 0 : ($urandom_range(0, 3) == 0 ? $urandom_range(0, 13) : 0);
		repeat (gap) @(posedge clk);
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {7'd0, mark, len};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		board.note_request(kind, len, mark);
		s_tvalid <= 1'b0;
		// the block drops s_tready after a transfer until its grant is taken
		@(posedge clk);
	endtask

	task automatic drain();
		while (board.owed.size() != 0) @(posedge clk);
	endtask

	// random request, mostly sensible lengths with a few edge values
	task automatic random_request();
		logic [2:0] kind;
		logic [8:0] len;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 20) kind = KIND_FIRST;
		else if (pick < 40) kind = KIND_BEST;
		else if (pick < 60) kind = KIND_WORST;
		else if (pick < 78) kind = KIND_NEXT;
		else if (pick < 96) kind = KIND_MARK;
		else kind = 3'($urandom_range(5, 7));
		pick = $urandom_range(0, 99);
		if (pick < 70) len = 9'($urandom_range(1, 24));
		else if (pick < 90) len = 9'($urandom_range(25, 256));
		else len = 9'($urandom);
		send_request(kind, len, 8'($urandom));
	endtask

	// sink: random stalls per transfer, plus the long forced hold
	initial begin
		int wait_n;
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			wait_n = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 13) : 0;
			repeat (wait_n) @(posedge clk);
			while (hold_sink) @(posedge clk);
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
			board.check_grant(m_tdata);
			m_tready <= 1'b0;
			@(posedge clk);
		end
	end

	// watchdog on cycles with no transfer on either side
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 20000) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	initial begin
		board = new();
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tuser <= KIND_FIRST;
		s_tdata <= '0;
		hold_sink = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: zero and oversized lengths, unused kinds, every policy
		send_request(KIND_FIRST, 9'd0, 8'd0);
		send_request(KIND_BEST, 9'd257, 8'd0);
		send_request(KIND_WORST, 9'd511, 8'hff);
		send_request(3'd5, 9'd4, 8'd0);
		send_request(3'd7, 9'd4, 8'd0);
		send_request(KIND_MARK, 9'd0, 8'd10);
		send_request(KIND_MARK, 9'd511, 8'd10);  // already occupied
		send_request(KIND_MARK, 9'd1, 8'd255);
		send_request(KIND_MARK, 9'd1, 8'd0);
		send_request(KIND_MARK, 9'd1, 8'd20);
		send_request(KIND_FIRST, 9'd3, 8'd0);
		send_request(KIND_BEST, 9'd9, 8'd0);     // exact hole between marks
		send_request(KIND_WORST, 9'd5, 8'd0);
		send_request(KIND_NEXT, 9'd200, 8'd0);
		send_request(KIND_NEXT, 9'd100, 8'd0);   // runs off the end
		send_request(KIND_FIRST, 9'd256, 8'd0);  // whole map, cannot fit now
		drain();

		// long sink hold so the block backs up its input
		hold_sink = 1;
		fork
			begin
				repeat (3000) @(posedge clk);
				hold_sink = 0;
			end
			repeat (6) random_request();
		join

		// random phase; the sender pauses for a full drain now and then
		for (int n = 0; n < 1400; n++) begin
			random_request();
			if (n % 300 == 299) drain();
			// fresh map only by filling: mark many units to reach next fit at end
		end
		// mark every 37th unit back to back, then next and first fit requests
		for (int u = 0; u < UNITS; u += 37) send_request(KIND_MARK, 9'd1, 8'(u), 1);
		send_request(KIND_NEXT, 9'd1, 8'd0);
		send_request(KIND_FIRST, 9'd1, 8'd0);
		send_request(KIND_NEXT, 9'd1, 8'd0);

		drain();
		repeat (600) @(posedge clk);
		if (board.errors == 0 && board.owed.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end
endmodule
`default_nettype wire
